// ----- hdl/pbct_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pbct_pkg
// shared types and constants for the per-host byte counter table
// ----------------------------------------------------------------------------
package pbct_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam logic [31:0] LIMIT_RESET = 32'd4294800000;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [7:0]  BCAST_OCTET = 8'hff;

    localparam logic ACT_COUNT = 1'b0;
    localparam logic ACT_READ  = 1'b1;
    localparam logic DIR_EGRESS = 1'b1;

    typedef enum logic [2:0] {
        ST_IGNORED = 3'd0,
        ST_HIT     = 3'd1,
        ST_NEW     = 3'd2,
        ST_EVICT   = 3'd3,
        ST_READ    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_MODIFY
    } state_t;

    typedef struct packed {
        logic        action;
        logic        direction;
        logic [7:0]  protocol;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] total_length;
        logic [31:0] now;
        logic [5:0]  read_index;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  slot;
        logic        entry_valid;
        logic [31:0] entry_address;
        logic [31:0] incoming_bytes;
        logic [31:0] outgoing_bytes;
    } result_t;

    // one table entry as held in memory
    typedef struct packed {
        logic [31:0] address;
        logic [31:0] in_count;
        logic [31:0] out_count;
        logic [31:0] last_seen;
    } entry_t;

endpackage
`default_nettype wire

// ----- hdl/pbct_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pbct_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module pbct_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 128,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/per_host_byte_counter_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// per_host_byte_counter_table
// table of host addresses with per-host incoming and outgoing byte counters
// ----------------------------------------------------------------------------
// usage
// - item channel (item_valid/item_ready/item): one packet to count or one
//   entry to read; ready is high only while no transaction is being worked on
// - result channel (result_valid/result_ready/result): exactly one result
//   per item, held in an output register until the receiver takes it
// - cfg channel (cfg_valid/cfg_ready/cfg_data): writes counter_limit, always
//   ready; write it only while the block is idle
// - a counted packet scans every entry, one memory read a cycle, for a
//   matching host, the first empty entry and the oldest entry; it then
//   fetches the chosen entry and writes it back, registering the result;
//   the next item can be accepted once the block is back in idle
// - a read item fetches its entry and then gives its result, an ignored
//   packet gives its result without a fetch; both then return to idle
// - the single read port of the entry memory and the linear scan set the rate
// - reset empties the table at once through per-entry valid bits and loads
//   counter_limit with its reset value; no clearing pass is needed
// - a stalled receiver holds the finished result; the next item can be
//   accepted and worked on, and stalls only when its own result is ready
// ----------------------------------------------------------------------------
module per_host_byte_counter_table (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire pbct_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output pbct_pkg::result_t      result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [31:0]       cfg_data
);

    import pbct_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // control state
    state_t                 state_reg, state_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [31:0]            limit_reg;
    logic                   result_valid_reg, result_valid_next;
    logic [IDX_W:0]         cnt_reg, cnt_next;
    logic                   pend_reg, pend_next;
    logic                   found_hit_reg, found_hit_next;
    logic                   found_empty_reg, found_empty_next;
    logic                   have_old_reg, have_old_next;

    // payload state
    item_t                  item_reg, item_next;
    logic [31:0]            key_reg, key_next;
    logic [IDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]       empty_idx_reg, empty_idx_next;
    logic [IDX_W-1:0]       old_idx_reg, old_idx_next;
    logic [31:0]            old_time_reg, old_time_next;
    logic [IDX_W-1:0]       sel_idx_reg, sel_idx_next;
    status_t                status_reg, status_next;
    result_t                result_reg, result_next;

    // memory port
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    entry_t                 mem_wdata;
    logic                   mem_re;
    logic [IDX_W-1:0]       mem_raddr;
    entry_t                 mem_rdata;

    // update datapath
    logic                   ignore;
    logic                   is_hit;
    logic [31:0]            in_base;
    logic [31:0]            out_base;
    logic [31:0]            add_base;
    logic [32:0]            sum;
    logic [31:0]            upd_count;
    logic                   rd_valid;

    pbct_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH ($bits(entry_t))
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    // packet filter: only tcp/udp, nonzero length, no broadcast destination
    assign ignore = ((item.protocol != PROTO_TCP) && (item.protocol != PROTO_UDP))
                    || (item.total_length == 16'd0)
                    || (item.dest_address[7:0] == BCAST_OCTET);

    // counter update for the selected entry, sum kept one bit wider than the count
    assign is_hit    = (status_reg == ST_HIT);
    assign in_base   = is_hit ? mem_rdata.in_count  : 32'd0;
    assign out_base  = is_hit ? mem_rdata.out_count : 32'd0;
    assign add_base  = (item_reg.direction == DIR_EGRESS) ? in_base : out_base;
    assign sum       = {1'b0, add_base} + {17'd0, item_reg.total_length};
    assign upd_count = (sum > {1'b0, limit_reg}) ? 32'd0 : sum[31:0];
    assign rd_valid  = valid_reg[sel_idx_reg];

    always_comb
    begin
        state_next        = state_reg;
        valid_next        = valid_reg;
        result_valid_next = result_valid_reg;
        cnt_next          = cnt_reg;
        pend_next         = 1'b0;
        found_hit_next    = found_hit_reg;
        found_empty_next  = found_empty_reg;
        have_old_next     = have_old_reg;
        item_next         = item_reg;
        key_next          = key_reg;
        pend_idx_next     = pend_idx_reg;
        hit_idx_next      = hit_idx_reg;
        empty_idx_next    = empty_idx_reg;
        old_idx_next      = old_idx_reg;
        old_time_next     = old_time_reg;
        sel_idx_next      = sel_idx_reg;
        status_next       = status_reg;
        result_next       = result_reg;
        mem_we            = 1'b0;
        mem_waddr         = sel_idx_reg;
        mem_wdata         = '0;
        mem_re            = 1'b0;
        mem_raddr         = sel_idx_reg;

        // receiver takes the held result
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next        = item;
                    key_next         = (item.direction == DIR_EGRESS) ?
                                       item.dest_address : item.source_address;
                    cnt_next         = '0;
                    found_hit_next   = 1'b0;
                    found_empty_next = 1'b0;
                    have_old_next    = 1'b0;
                    sel_idx_next     = item.read_index[IDX_W-1:0];
                    if (item.action == ACT_READ)
                    begin
                        status_next = ST_READ;
                        state_next  = S_FETCH;
                    end
                    else if (ignore)
                    begin
                        status_next = ST_IGNORED;
                        state_next  = S_MODIFY;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one read a cycle, compare the previous one
                if (!cnt_reg[IDX_W])
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = cnt_reg[IDX_W-1:0];
                    cnt_next      = cnt_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = cnt_reg[IDX_W-1:0];
                end
                if (pend_reg)
                begin
                    if (valid_reg[pend_idx_reg])
                    begin
                        if (!found_hit_reg && (mem_rdata.address == key_reg))
                        begin
                            found_hit_next = 1'b1;
                            hit_idx_next   = pend_idx_reg;
                        end
                        if (!have_old_reg || (mem_rdata.last_seen < old_time_reg))
                        begin
                            have_old_next = 1'b1;
                            old_idx_next  = pend_idx_reg;
                            old_time_next = mem_rdata.last_seen;
                        end
                    end
                    else if (!found_empty_reg)
                    begin
                        found_empty_next = 1'b1;
                        empty_idx_next   = pend_idx_reg;
                    end
                    if (pend_idx_reg == LAST_IDX)
                    begin
                        // last entry compared: pick hit, then empty, then oldest
                        state_next = S_FETCH;
                        if (found_hit_next)
                        begin
                            sel_idx_next = hit_idx_next;
                            status_next  = ST_HIT;
                        end
                        else if (found_empty_next)
                        begin
                            sel_idx_next = empty_idx_next;
                            status_next  = ST_NEW;
                        end
                        else
                        begin
                            sel_idx_next = old_idx_next;
                            status_next  = ST_EVICT;
                        end
                    end
                end
            end

            S_FETCH:
            begin
                mem_re     = 1'b1;
                mem_raddr  = sel_idx_reg;
                state_next = S_MODIFY;
            end

            S_MODIFY:
            begin
                // wait for room in the output register
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                    result_next       = '0;
                    result_next.status = status_reg;
                    case (status_reg)
                        ST_IGNORED:
                        begin
                            result_next.slot = '0;
                        end
                        ST_READ:
                        begin
                            result_next.slot        = item_reg.read_index;
                            result_next.entry_valid = rd_valid;
                            if (rd_valid)
                            begin
                                result_next.entry_address  = mem_rdata.address;
                                result_next.incoming_bytes = mem_rdata.in_count;
                                result_next.outgoing_bytes = mem_rdata.out_count;
                            end
                        end
                        default:
                        begin
                            mem_we              = 1'b1;
                            mem_waddr           = sel_idx_reg;
                            mem_wdata.address   = key_reg;
                            mem_wdata.in_count  = in_base;
                            mem_wdata.out_count = out_base;
                            if (item_reg.direction == DIR_EGRESS)
                            begin
                                mem_wdata.in_count = upd_count;
                            end
                            else
                            begin
                                mem_wdata.out_count = upd_count;
                            end
                            mem_wdata.last_seen     = item_reg.now;
                            valid_next[sel_idx_reg] = 1'b1;
                            result_next.slot           = 6'(sel_idx_reg);
                            result_next.entry_valid    = 1'b1;
                            result_next.entry_address  = key_reg;
                            result_next.incoming_bytes = mem_wdata.in_count;
                            result_next.outgoing_bytes = mem_wdata.out_count;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            valid_reg        <= '0;
            limit_reg        <= LIMIT_RESET;
            result_valid_reg <= 1'b0;
            cnt_reg          <= '0;
            pend_reg         <= 1'b0;
            found_hit_reg    <= 1'b0;
            found_empty_reg  <= 1'b0;
            have_old_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            valid_reg        <= valid_next;
            result_valid_reg <= result_valid_next;
            cnt_reg          <= cnt_next;
            pend_reg         <= pend_next;
            found_hit_reg    <= found_hit_next;
            found_empty_reg  <= found_empty_next;
            have_old_reg     <= have_old_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        key_reg       <= key_next;
        pend_idx_reg  <= pend_idx_next;
        hit_idx_reg   <= hit_idx_next;
        empty_idx_reg <= empty_idx_next;
        old_idx_reg   <= old_idx_next;
        old_time_reg  <= old_time_next;
        sel_idx_reg   <= sel_idx_next;
        status_reg    <= status_next;
        result_reg    <= result_next;
    end

endmodule
`default_nettype wire
